[design/rmmsq_pkg.sv]
// ---------------------------------------------------------------------------
// rmmsq_pkg
// Shared types and codes for the range min/max/sum query block.
// ---------------------------------------------------------------------------
package rmmsq_pkg;

   localparam int IDX_W   = 6;
   localparam int DATA_W  = 32;
   localparam int LEN_W   = 7;
   localparam int PADDR_W = 3;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_RANGE_ERR = 1'b1;

   localparam logic [PADDR_W-3:0] REG_ARRAY_LENGTH = '0;
   localparam logic [LEN_W-1:0]   ARRAY_LENGTH_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]              func;
      logic [IDX_W-1:0]        first_index;
      logic [IDX_W-1:0]        last_index;
      logic signed [DATA_W-1:0] write_value;
      logic signed [DATA_W-1:0] delta;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_min;
      logic signed [DATA_W-1:0] range_max;
      logic signed [DATA_W-1:0] range_sum;
      logic                     status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

[design/rmmsq_chan_if.sv]
// ---------------------------------------------------------------------------
// rmmsq_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ---------------------------------------------------------------------------
interface rmmsq_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/rmmsq_ram.sv]
// ---------------------------------------------------------------------------
// rmmsq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module rmmsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[design/range_min_max_sum_query.sv]
// Sequence: a write, an error, a reversed add or an unused selector goes from IDLE to DONE and
//   then to the result register; an add or a query walks the range through WALK and DRAIN first.
// Throughput: one word at a time; the next word is accepted once the current one reaches
//   the result register. The walk over the value RAM (one read a cycle) and a held result set it.
// Reset: synchronous, active high. After reset a clearing pass writes zero to all
//   MAX_ELEMENTS entries, one per cycle, before the first word is accepted.
// ---------------------------------------------------------------------------
// range_min_max_sum_query
// Array of signed 32-bit values with element write, range add and range
// min/max/sum query, walked one element per cycle through a RAM.
// ---------------------------------------------------------------------------
module range_min_max_sum_query #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   rmmsq_chan_if.sink                         req_chan,
   rmmsq_chan_if.source                       rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rmmsq_pkg::PADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import rmmsq_pkg::*;

   // Address width of the value RAM, and widths used to compare indices
   // against the length in use.
   localparam int AW   = $clog2(MAX_ELEMENTS);
   localparam int ULW  = $clog2(MAX_ELEMENTS + 1);
   localparam int CW   = (ULW > LEN_W) ? ULW : LEN_W;
   localparam logic [CW-1:0] MAX_LEN   = CW'(MAX_ELEMENTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic [LEN_W-1:0]         array_length_ff, array_length_in;

   // Captured word
   logic [1:0]               op_ff, op_in;
   logic                     err_ff, err_in;
   logic [AW-1:0]            addr_ff, addr_in;     // next address to read
   logic [AW-1:0]            hi_ff, hi_in;         // last address of the walk
   logic signed [DATA_W-1:0] delta_ff, delta_in;

   // Read pipeline: one entry in flight behind the RAM read register
   logic                     pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]            pipe_addr_ff, pipe_addr_in;
   logic                     first_ff, first_in;

   // Accumulators
   logic signed [DATA_W-1:0] min_ff, min_in;
   logic signed [DATA_W-1:0] max_ff, max_in;
   logic signed [DATA_W-1:0] sum_ff, sum_in;

   // Result register
   logic                     rsp_vld_ff, rsp_vld_in;
   rsp_type                  rsp_ff, rsp_in;

   // ------------------------------------------------------------------
   // RAM port signals
   // ------------------------------------------------------------------
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic                     rd_en;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_value;

   // ------------------------------------------------------------------
   // Decode of the incoming word
   // ------------------------------------------------------------------
   logic [CW-1:0]            used_len;
   logic [CW-1:0]            first_ext, last_ext;
   logic                     first_bad, last_bad;
   logic                     req_err;
   logic                     reversed;
   logic [AW-1:0]            first_addr, last_addr;
   logic                     rsp_free;
   logic                     csr_wr;
   logic [PADDR_W-3:0]       csr_index;

   assign rsp_free   = !rsp_vld_ff || rsp_chan.ready;
   assign rd_value   = $signed(rd_data);

   // Saturate the configured length at the RAM depth.
   always_comb begin
      used_len = CW'(array_length_ff);
      if (used_len > MAX_LEN) begin
         used_len = MAX_LEN;
      end
   end

   assign first_ext  = CW'(req_chan.payload.first_index);
   assign last_ext   = CW'(req_chan.payload.last_index);
   assign first_bad  = (first_ext >= used_len);
   assign last_bad   = (last_ext >= used_len);
   assign reversed   = (req_chan.payload.first_index > req_chan.payload.last_index);
   assign first_addr = AW'(req_chan.payload.first_index);
   assign last_addr  = AW'(req_chan.payload.last_index);

   // A write checks only its element; add and query check both ends.
   always_comb begin
      unique case (req_chan.payload.func) inside
         FUNC_WRITE:           req_err = first_bad;
         FUNC_ADD, FUNC_QUERY: req_err = first_bad || last_bad;
         default:              req_err = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[PADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_ARRAY_LENGTH) ?
                       {{(32-LEN_W){1'b0}}, array_length_ff} : 32'd0;

   always_comb begin
      array_length_in = array_length_ff;
      if (csr_wr && (csr_index == REG_ARRAY_LENGTH)) begin
         array_length_in = csr_pwdata[LEN_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer: clear, accept, walk, drain, deliver
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      addr_in      = addr_ff;
      hi_in        = hi_ff;
      delta_in     = delta_ff;
      pipe_vld_in  = 1'b0;
      pipe_addr_in = addr_ff;
      first_in     = first_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_in       = rsp_ff;

      wr_en        = 1'b0;
      wr_addr      = pipe_addr_ff;
      wr_data      = DATA_W'(rd_value + delta_ff);
      rd_en        = 1'b0;
      req_chan.ready = 1'b0;

      // Drop the result once the sink takes it.
      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      // Fold the element that comes back from the RAM this cycle.
      if (pipe_vld_ff) begin
         if (op_ff == FUNC_ADD) begin
            wr_en = 1'b1;
         end
         first_in = 1'b0;
         if (first_ff) begin
            min_in = rd_value;
            max_in = rd_value;
            sum_in = rd_value;
         end else begin
            if (rd_value < min_ff) begin
               min_in = rd_value;
            end
            if (rd_value > max_ff) begin
               max_in = rd_value;
            end
            sum_in = DATA_W'(sum_ff + rd_value);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one entry per cycle after reset.
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            // Ready is high in this state, so valid alone marks an accept.
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in    = req_chan.payload.func;
               err_in   = req_err;
               delta_in = req_chan.payload.delta;
               first_in = 1'b1;
               // Walk upward from the lower index of the range.
               if (reversed) begin
                  addr_in = last_addr;
                  hi_in   = first_addr;
               end else begin
                  addr_in = first_addr;
                  hi_in   = last_addr;
               end
               state_in = ST_DONE;
               case (req_chan.payload.func)
                  FUNC_WRITE: begin
                     if (!req_err) begin
                        wr_en   = 1'b1;
                        wr_addr = first_addr;
                        wr_data = req_chan.payload.write_value;
                     end
                  end
                  FUNC_ADD: begin
                     // A reversed add changes nothing.
                     if (!req_err && !reversed) begin
                        state_in = ST_WALK;
                     end
                  end
                  FUNC_QUERY: begin
                     if (!req_err) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // Issue one read a cycle; the write-back trails by one entry.
            rd_en        = 1'b1;
            pipe_vld_in  = 1'b1;
            pipe_addr_in = addr_ff;
            if (addr_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_DRAIN: begin
            // Last element folds in this cycle.
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Hold until the result register is free.
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_in.status = err_ff ? STATUS_RANGE_ERR : STATUS_OK;
               if ((op_ff == FUNC_QUERY) && !err_ff) begin
                  rsp_in.range_min = min_ff;
                  rsp_in.range_max = max_ff;
                  rsp_in.range_sum = sum_ff;
               end else begin
                  rsp_in.range_min = '0;
                  rsp_in.range_max = '0;
                  rsp_in.range_sum = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         array_length_ff <= ARRAY_LENGTH_RESET;
         pipe_vld_ff     <= 1'b0;
         rsp_vld_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         array_length_ff <= array_length_in;
         pipe_vld_ff     <= pipe_vld_in;
         rsp_vld_ff      <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      err_ff       <= err_in;
      addr_ff      <= addr_in;
      hi_ff        <= hi_in;
      delta_ff     <= delta_in;
      pipe_addr_ff <= pipe_addr_in;
      first_ff     <= first_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      sum_ff       <= sum_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

   // ------------------------------------------------------------------
   // Value store
   // ------------------------------------------------------------------
   rmmsq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

endmodule
